@@ hw/rtl/rbs_pkg.sv @@
// Shared types, widths and helpers for the ray/box slab intersect pipeline.
package rbs_pkg;

   localparam int COORD_W    = 24;
   localparam int DIR_W      = 16;
   localparam int SIZE_W     = 23;
   localparam int THR_W      = 15;
   localparam int DIST_W     = 32;
   localparam int BOUND_W    = COORD_W + 1;
   localparam int DIFF_W     = COORD_W + 2;
   localparam int FRAC_SHIFT = 10;
   localparam int NUM_W      = DIFF_W + FRAC_SHIFT;
   localparam int DVS_W      = DIR_W + 1;
   localparam int STEP_BITS  = 4;
   localparam int DIV_STAGES = NUM_W / STEP_BITS;
   localparam int T_W        = NUM_W + 2;
   localparam int HALF_W     = NUM_W / 2;
   localparam int PROD_W     = DIR_W + HALF_W + 1;
   localparam int SUM_W      = PROD_W + HALF_W + 1;
   localparam int LANES      = 4;

   localparam int LANE_XLO = 0;
   localparam int LANE_XHI = 1;
   localparam int LANE_YLO = 2;
   localparam int LANE_YHI = 3;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   typedef struct packed {
      logic signed [COORD_W-1:0] ray_origin_x;
      logic signed [COORD_W-1:0] ray_origin_y;
      logic signed [DIR_W-1:0]   ray_dir_x;
      logic signed [DIR_W-1:0]   ray_dir_y;
      logic signed [COORD_W-1:0] rect_x;
      logic signed [COORD_W-1:0] rect_y;
      logic [SIZE_W-1:0]         rect_width;
      logic [SIZE_W-1:0]         rect_height;
   } req_word_type;

   typedef struct packed {
      logic                      hit;
      logic [DIST_W-1:0]         distance;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } rsp_word_type;

   // One restoring divider lane: quotient bits shift into num from the bottom.
   typedef struct packed {
      logic [DVS_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [DVS_W-1:0] dvs;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [DIR_W-1:0]   dx;
      logic signed [DIR_W-1:0]   dy;
      logic                      par_x;
      logic                      par_y;
      logic                      miss;
      div_lane_type [LANES-1:0]  lane;
   } div_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]   ox;
      logic signed [COORD_W-1:0]   oy;
      logic signed [DIR_W-1:0]     dx;
      logic signed [DIR_W-1:0]     dy;
      logic                        par_x;
      logic                        par_y;
      logic                        miss;
      logic [LANES-1:0][T_W-1:0]   t;
   } fix_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [DIR_W-1:0]   dx;
      logic signed [DIR_W-1:0]   dy;
      logic                      miss;
      logic [NUM_W-1:0]          tmin;
      logic signed [T_W-1:0]     tmax;
      logic                      tmax_unb;
   } comb_word_type;

   typedef struct packed {
      logic                      hit;
      logic [DIST_W-1:0]         t_entry;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [PROD_W-1:0]  pl_x;
      logic signed [PROD_W-1:0]  ph_x;
      logic signed [PROD_W-1:0]  pl_y;
      logic signed [PROD_W-1:0]  ph_y;
   } prod_word_type;

   typedef struct packed {
      logic                      hit;
      logic [DIST_W-1:0]         t_entry;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [SUM_W-1:0]   sum_x;
      logic signed [SUM_W-1:0]   sum_y;
   } sum_word_type;

   // Set up one divider lane for (bound - origin) * 1024 / dir.
   function automatic div_lane_type make_lane(input logic signed [DIFF_W-1:0] diff,
                                              input logic signed [DIR_W-1:0] dir);
      div_lane_type           l;
      logic [DIFF_W-1:0]      mag;
      logic [DVS_W-1:0]       dext;
      dext  = {dir[DIR_W-1], dir};
      mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      l.rem = '0;
      l.num = {mag, {FRAC_SHIFT{1'b0}}};
      l.dvs = dir[DIR_W-1] ? DVS_W'(-dext) : dext;
      l.neg = diff[DIFF_W-1] ^ dir[DIR_W-1];
      return l;
   endfunction

endpackage

@@ hw/rtl/rbs_prep.sv @@
// Front stage: slab bounds, parallel checks and divider lane setup.
module rbs_prep import rbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  req_word_type       in_word,
   input  logic [THR_W-1:0]   thr,
   output logic               out_valid,
   output div_word_type       out_word
);

   logic                       valid_ff;
   div_word_type               word_ff;
   div_word_type               word_in;
   logic signed [BOUND_W-1:0]  lo_x, hi_x, lo_y, hi_y, org_x, org_y;
   logic [DVS_W-1:0]           dmag_x, dmag_y, dext_x, dext_y;
   logic                       in_x, in_y;

   always_comb begin
      lo_x   = {in_word.rect_x[COORD_W-1], in_word.rect_x};
      lo_y   = {in_word.rect_y[COORD_W-1], in_word.rect_y};
      hi_x   = lo_x + $signed({2'b00, in_word.rect_width});
      hi_y   = lo_y + $signed({2'b00, in_word.rect_height});
      org_x  = {in_word.ray_origin_x[COORD_W-1], in_word.ray_origin_x};
      org_y  = {in_word.ray_origin_y[COORD_W-1], in_word.ray_origin_y};
      dext_x = {in_word.ray_dir_x[DIR_W-1], in_word.ray_dir_x};
      dext_y = {in_word.ray_dir_y[DIR_W-1], in_word.ray_dir_y};
      dmag_x = in_word.ray_dir_x[DIR_W-1] ? DVS_W'(-dext_x) : dext_x;
      dmag_y = in_word.ray_dir_y[DIR_W-1] ? DVS_W'(-dext_y) : dext_y;
      in_x   = (org_x >= lo_x) && (org_x <= hi_x);
      in_y   = (org_y >= lo_y) && (org_y <= hi_y);

      word_in.ox    = in_word.ray_origin_x;
      word_in.oy    = in_word.ray_origin_y;
      word_in.dx    = in_word.ray_dir_x;
      word_in.dy    = in_word.ray_dir_y;
      word_in.par_x = dmag_x <= {2'b00, thr};
      word_in.par_y = dmag_y <= {2'b00, thr};
      word_in.miss  = (word_in.par_x && !in_x) || (word_in.par_y && !in_y);
      word_in.lane[LANE_XLO] = make_lane({lo_x[BOUND_W-1], lo_x} - {org_x[BOUND_W-1], org_x},
                                         in_word.ray_dir_x);
      word_in.lane[LANE_XHI] = make_lane({hi_x[BOUND_W-1], hi_x} - {org_x[BOUND_W-1], org_x},
                                         in_word.ray_dir_x);
      word_in.lane[LANE_YLO] = make_lane({lo_y[BOUND_W-1], lo_y} - {org_y[BOUND_W-1], org_y},
                                         in_word.ray_dir_y);
      word_in.lane[LANE_YHI] = make_lane({hi_y[BOUND_W-1], hi_y} - {org_y[BOUND_W-1], org_y},
                                         in_word.ray_dir_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ hw/rtl/rbs_div_stage.sv @@
// One divider stage: STEP_BITS restoring quotient bits on all four lanes.
module rbs_div_stage import rbs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  div_word_type  in_word,
   output logic          out_valid,
   output div_word_type  out_word
);

   logic          valid_ff;
   div_word_type  word_ff;
   div_word_type  word_in;
   logic [DVS_W:0]   sh;
   logic [DVS_W-1:0] r;
   logic [NUM_W-1:0] n;

   always_comb begin
      word_in = in_word;
      sh = '0;
      r  = '0;
      n  = '0;
      for (int l = 0; l < LANES; l++) begin
         r = in_word.lane[l].rem;
         n = in_word.lane[l].num;
         for (int k = 0; k < STEP_BITS; k++) begin
            sh = {r, n[NUM_W-1]};
            n  = {n[NUM_W-2:0], 1'b0};
            if (sh >= {1'b0, in_word.lane[l].dvs}) begin
               sh   = sh - {1'b0, in_word.lane[l].dvs};
               n[0] = 1'b1;
            end
            r = sh[DVS_W-1:0];
         end
         word_in.lane[l].rem = r;
         word_in.lane[l].num = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ hw/rtl/rbs_slab.sv @@
// Floor-correct the quotients, then merge both slabs into entry and exit.
module rbs_slab import rbs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  div_word_type   in_word,
   output logic           out_valid,
   output comb_word_type  out_word
);

   logic           fix_valid_ff, comb_valid_ff;
   fix_word_type   fix_ff, fix_in;
   comb_word_type  comb_ff, comb_in;
   logic [T_W-1:0]        tq;
   logic signed [T_W-1:0] t1x, t2x, t1y, t2y, tmin;

   always_comb begin
      fix_in.ox    = in_word.ox;
      fix_in.oy    = in_word.oy;
      fix_in.dx    = in_word.dx;
      fix_in.dy    = in_word.dy;
      fix_in.par_x = in_word.par_x;
      fix_in.par_y = in_word.par_y;
      fix_in.miss  = in_word.miss;
      tq = '0;
      for (int l = 0; l < LANES; l++) begin
         tq = {2'b00, in_word.lane[l].num};
         // floor of a negative quotient: -q - 1 when a remainder is left
         if (in_word.lane[l].neg) begin
            fix_in.t[l] = ~tq + {{(T_W-1){1'b0}}, (in_word.lane[l].rem == '0)};
         end else begin
            fix_in.t[l] = tq;
         end
      end
   end

   always_comb begin
      if ($signed(fix_ff.t[LANE_XLO]) > $signed(fix_ff.t[LANE_XHI])) begin
         t1x = $signed(fix_ff.t[LANE_XHI]);
         t2x = $signed(fix_ff.t[LANE_XLO]);
      end else begin
         t1x = $signed(fix_ff.t[LANE_XLO]);
         t2x = $signed(fix_ff.t[LANE_XHI]);
      end
      if ($signed(fix_ff.t[LANE_YLO]) > $signed(fix_ff.t[LANE_YHI])) begin
         t1y = $signed(fix_ff.t[LANE_YHI]);
         t2y = $signed(fix_ff.t[LANE_YLO]);
      end else begin
         t1y = $signed(fix_ff.t[LANE_YLO]);
         t2y = $signed(fix_ff.t[LANE_YHI]);
      end
      tmin = '0;
      if (!fix_ff.par_x && t1x > tmin) begin
         tmin = t1x;
      end
      if (!fix_ff.par_y && t1y > tmin) begin
         tmin = t1y;
      end
      comb_in.tmax     = '0;
      comb_in.tmax_unb = 1'b1;
      if (!fix_ff.par_x) begin
         comb_in.tmax     = t2x;
         comb_in.tmax_unb = 1'b0;
      end
      if (!fix_ff.par_y && (comb_in.tmax_unb || t2y < comb_in.tmax)) begin
         comb_in.tmax     = t2y;
         comb_in.tmax_unb = 1'b0;
      end
      comb_in.tmin = tmin[NUM_W-1:0];
      comb_in.ox   = fix_ff.ox;
      comb_in.oy   = fix_ff.oy;
      comb_in.dx   = fix_ff.dx;
      comb_in.dy   = fix_ff.dy;
      comb_in.miss = fix_ff.miss;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_valid_ff  <= 1'b0;
         comb_valid_ff <= 1'b0;
      end else if (en) begin
         fix_valid_ff  <= in_valid;
         comb_valid_ff <= fix_valid_ff;
      end
      if (en) begin
         fix_ff  <= fix_in;
         comb_ff <= comb_in;
      end
   end

   assign out_valid = comb_valid_ff;
   assign out_word  = comb_ff;

endmodule

@@ hw/rtl/rbs_point.sv @@
// Hit decision, split multiply for the hit point, rounding and saturation.
module rbs_point import rbs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  comb_word_type  in_word,
   output logic           out_valid,
   output rsp_word_type   out_word
);

   logic           prod_valid_ff, sum_valid_ff, out_valid_ff;
   prod_word_type  prod_ff, prod_in;
   sum_word_type   sum_ff, sum_in;
   rsp_word_type   out_ff, out_in;
   logic signed [HALF_W:0]  tlo, thi;
   logic signed [SUM_W-1:0] vx, vy;
   logic                    hit;

   function automatic logic signed [SUM_W-1:0] join_prod(input logic signed [PROD_W-1:0] ph,
                                                         input logic signed [PROD_W-1:0] pl);
      logic signed [SUM_W-1:0] h, l;
      h = {{(SUM_W-PROD_W){ph[PROD_W-1]}}, ph};
      l = {{(SUM_W-PROD_W){pl[PROD_W-1]}}, pl};
      return (h <<< HALF_W) + l + SUM_W'(1 << (FRAC_SHIFT - 1));
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-COORD_W:0] top;
      top = v[SUM_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
         return v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   always_comb begin
      tlo = $signed({1'b0, in_word.tmin[HALF_W-1:0]});
      thi = $signed({1'b0, in_word.tmin[NUM_W-1:HALF_W]});
      hit = !in_word.miss &&
            (in_word.tmax_unb || $signed({2'b00, in_word.tmin}) <= in_word.tmax);
      prod_in.hit     = hit;
      prod_in.t_entry = (|in_word.tmin[NUM_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                        : in_word.tmin[DIST_W-1:0];
      prod_in.ox   = in_word.ox;
      prod_in.oy   = in_word.oy;
      prod_in.pl_x = in_word.dx * tlo;
      prod_in.ph_x = in_word.dx * thi;
      prod_in.pl_y = in_word.dy * tlo;
      prod_in.ph_y = in_word.dy * thi;
   end

   always_comb begin
      sum_in.hit     = prod_ff.hit;
      sum_in.t_entry = prod_ff.t_entry;
      sum_in.ox      = prod_ff.ox;
      sum_in.oy      = prod_ff.oy;
      sum_in.sum_x   = join_prod(prod_ff.ph_x, prod_ff.pl_x);
      sum_in.sum_y   = join_prod(prod_ff.ph_y, prod_ff.pl_y);
   end

   always_comb begin
      vx = (sum_ff.sum_x >>> FRAC_SHIFT) +
           $signed({{(SUM_W-COORD_W){sum_ff.ox[COORD_W-1]}}, sum_ff.ox});
      vy = (sum_ff.sum_y >>> FRAC_SHIFT) +
           $signed({{(SUM_W-COORD_W){sum_ff.oy[COORD_W-1]}}, sum_ff.oy});
      out_in.hit = sum_ff.hit;
      if (sum_ff.hit) begin
         out_in.distance = sum_ff.t_entry;
         out_in.point_x  = sat_coord(vx);
         out_in.point_y  = sat_coord(vy);
      end else begin
         out_in.distance = '0;
         out_in.point_x  = '0;
         out_in.point_y  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
         sum_valid_ff  <= prod_valid_ff;
         out_valid_ff  <= sum_valid_ff;
      end
      if (en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

endmodule

@@ hw/rtl/ray_box_slab_intersect.sv @@
// Pipeline from an accepted req word to its rsp word: 1 setup, 9 divider,
// 2 slab merge and 3 multiply/round/saturate stages.
// Throughput: one word per cycle; the whole pipeline holds while a rsp word is stalled.
// Reset (synchronous): all stage valid bits clear, the threshold register returns to 1.
// The csr port is always ready.
module ray_box_slab_intersect import rbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [THR_W-1:0]  csr_data
);

   logic [THR_W-1:0]  thr_ff;
   logic              en;
   logic [DIV_STAGES:0] div_valid;
   div_word_type        div_word [DIV_STAGES+1];
   logic              slab_valid;
   comb_word_type     slab_word;

   // advance everything unless the output word is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   rbs_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .thr       (thr_ff),
      .out_valid (div_valid[0]),
      .out_word  (div_word[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      rbs_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[s]),
         .in_word   (div_word[s]),
         .out_valid (div_valid[s+1]),
         .out_word  (div_word[s+1])
      );
   end

   rbs_slab u_slab (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid[DIV_STAGES]),
      .in_word   (div_word[DIV_STAGES]),
      .out_valid (slab_valid),
      .out_word  (slab_word)
   );

   rbs_point u_point (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (slab_valid),
      .in_word   (slab_word),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule

@@ dv/tb_ray_box_slab_intersect.sv @@
// Testbench for ray_box_slab_intersect: table-driven and random rays checked against a predictor.
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect;
   import rbs_pkg::*;

   localparam int     IDLE_PCT     = 32;
   localparam int     WATCHDOG_MAX = 4000;
   localparam int     DRAIN_CYCLES = 30;
   localparam int     PHASE_ITEMS  = 360;
   localparam longint T_OPEN       = 64'sh7fff_ffff_ffff_ffff;

   typedef struct {
      req_word_type ray;
      bit           typed;
      rsp_word_type hit;
   } ray_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_word_type     req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [THR_W-1:0] csr_data = '0;

   // side data travels with each req word
   bit               req_typed = 1'b0;
   rsp_word_type     req_hit = '0;

   logic [THR_W-1:0] thr_cur = THR_RESET;
   rsp_word_type     hit_q[$];
   int               mismatches = 0;
   int               stall_cnt = 0;
   int               phase_num = 0;
   bit               send_quiet = 1'b0;
   bit               recv_quiet = 1'b0;
   bit               recv_hold = 1'b0;
   ray_row_type      rays[$];

   ray_box_slab_intersect dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      q = n / d;
      if (n % d != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint sat_coord(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // Clip [t_in, t_out] by one slab; return 0 when a parallel axis misses.
   function automatic bit clip_slab(longint org, longint dir, longint lo, longint hi,
                                    longint thr, inout longint t_in, inout longint t_out);
      longint mag, t1, t2, s;
      mag = dir < 0 ? -dir : dir;
      if (mag > thr) begin
         t1 = floor_div((lo - org) * 1024, dir);
         t2 = floor_div((hi - org) * 1024, dir);
         if (t1 > t2) begin
            s  = t1;
            t1 = t2;
            t2 = s;
         end
         if (t1 > t_in) t_in = t1;
         if (t2 < t_out) t_out = t2;
         return 1'b1;
      end
      return !(org < lo || org > hi);
   endfunction

   function automatic rsp_word_type ray_hit(req_word_type w, logic [THR_W-1:0] thr);
      rsp_word_type r;
      longint ox, oy, dx, dy, rx, ry, t_in, t_out;
      r     = '0;
      ox    = longint'(w.ray_origin_x);
      oy    = longint'(w.ray_origin_y);
      dx    = longint'(w.ray_dir_x);
      dy    = longint'(w.ray_dir_y);
      rx    = longint'(w.rect_x);
      ry    = longint'(w.rect_y);
      t_in  = 0;
      t_out = T_OPEN;
      if (!clip_slab(ox, dx, rx, rx + longint'(w.rect_width), longint'(thr), t_in, t_out))
         return r;
      if (!clip_slab(oy, dy, ry, ry + longint'(w.rect_height), longint'(thr), t_in, t_out))
         return r;
      if (t_in > t_out) return r;
      r.hit      = 1'b1;
      r.distance = t_in > 64'sh0_ffff_ffff ? 32'hffff_ffff : t_in[31:0];
      r.point_x  = COORD_W'(sat_coord(ox + floor_div(dx * t_in + 512, 1024)));
      r.point_y  = COORD_W'(sat_coord(oy + floor_div(dy * t_in + 512, 1024)));
      return r;
   endfunction

   function automatic req_word_type mk_ray(longint ox, longint oy, longint dx, longint dy,
                                           longint rx, longint ry, longint rw, longint rh);
      req_word_type w;
      w.ray_origin_x = COORD_W'(ox);
      w.ray_origin_y = COORD_W'(oy);
      w.ray_dir_x    = DIR_W'(dx);
      w.ray_dir_y    = DIR_W'(dy);
      w.rect_x       = COORD_W'(rx);
      w.rect_y       = COORD_W'(ry);
      w.rect_width   = SIZE_W'(rw);
      w.rect_height  = SIZE_W'(rh);
      return w;
   endfunction

   function automatic rsp_word_type mk_hit(bit h, longint d, longint px, longint py);
      rsp_word_type r;
      r.hit      = h;
      r.distance = DIST_W'(d);
      r.point_x  = COORD_W'(px);
      r.point_y  = COORD_W'(py);
      return r;
   endfunction

   function automatic void add_row(req_word_type w, bit typed, rsp_word_type e);
      ray_row_type row;
      row.ray   = w;
      row.typed = typed;
      row.hit   = e;
      rays.push_back(row);
   endfunction

   // Mostly aimed rays near a small box; the rest raw bits of every field.
   function automatic req_word_type rand_ray();
      req_word_type w;
      int           sel;
      logic [191:0] raw;
      sel = $urandom_range(99);
      if (sel < 20) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         w   = raw[$bits(req_word_type)-1:0];
      end else begin
         w = mk_ray(longint'($urandom_range(262144)) - 131072,
                    longint'($urandom_range(262144)) - 131072,
                    longint'($urandom_range(32768)) - 16384,
                    longint'($urandom_range(32768)) - 16384,
                    longint'($urandom_range(131072)) - 65536,
                    longint'($urandom_range(131072)) - 65536,
                    $urandom_range(65536), $urandom_range(65536));
         if (sel < 35) w.ray_dir_x = DIR_W'(longint'($urandom_range(80)) - 40);
         else if (sel < 50) w.ray_dir_y = DIR_W'(longint'($urandom_range(80)) - 40);
         else if (sel < 53) w.ray_dir_x = 16'sh8000;
         if (sel >= 90) begin
            w.rect_width  = $urandom_range(1) ? '0 : w.rect_width;
            w.rect_height = $urandom_range(1) ? '0 : w.rect_height;
         end
      end
      return w;
   endfunction

   task automatic send_ray(req_word_type w, bit typed, rsp_word_type e);
      while (!send_quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      req_typed <= typed;
      req_hit   <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_thr(logic [THR_W-1:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (hit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      thr_cur   = v;
      csr_valid <= 1'b0;
   endtask

   // accept side: predict each req word, watchdog on silence
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stall_cnt <= 0;
         else stall_cnt <= stall_cnt + 1;
         if (req_valid && !req_stall)
            hit_q.push_back(req_typed ? req_hit : ray_hit(req_word, thr_cur));
         if (stall_cnt >= WATCHDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= recv_hold || (!recv_quiet && $urandom_range(99) < IDLE_PCT);
   end

   // long hold-off fills the pipe; later a stretch with no stalls
   initial begin
      wait (phase_num == 1);
      repeat (60) @(posedge clock);
      recv_hold <= 1'b1;
      repeat (400) @(posedge clock);
      recv_hold  <= 1'b0;
      recv_quiet <= 1'b1;
      repeat (800) @(posedge clock);
      recv_quiet <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_q.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected rsp word %p", rsp_word);
         end else begin
            e = hit_q.pop_front();
            if (rsp_word.hit !== e.hit || rsp_word.distance !== e.distance ||
                rsp_word.point_x !== e.point_x || rsp_word.point_y !== e.point_y) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("mismatch: exp hit=%0d dist=%h px=%h py=%h, got %0d %h %h %h",
                           e.hit, e.distance, e.point_x, e.point_y, rsp_word.hit,
                           rsp_word.distance, rsp_word.point_x, rsp_word.point_y);
            end
         end
      end
   end

   initial begin
      rsp_word_type none;
      logic [THR_W-1:0] thr_set[5];
      none = '0;
      // both axes parallel, origin inside / outside
      add_row(mk_ray(0, 0, 0, 0, -4096, -4096, 8192, 8192), 1, mk_hit(1, 0, 0, 0));
      add_row(mk_ray(20000, 0, 0, 0, -4096, -4096, 8192, 8192), 1, none);
      // origin inside: entry clamps to zero
      add_row(mk_ray(100, -200, 11585, 11585, -4096, -4096, 8192, 8192), 1,
              mk_hit(1, 0, 100, -200));
      // straight along +x into the box, and pointing away
      add_row(mk_ray(0, 0, 16384, 0, 4096, -4096, 4096, 8192), 1, mk_hit(1, 256, 4096, 0));
      add_row(mk_ray(0, 0, -16384, 0, 4096, -4096, 4096, 8192), 1, none);
      // distance and point saturation, and other edge rays
      add_row(mk_ray(-8388608, 0, 2, 0, 8388607, -10, 0, 20), 0, none);
      add_row(mk_ray(8388607, -8388608, -32768, -32768, -8388608, -8388608, 8388607, 8388607),
              0, none);
      add_row(mk_ray(-8388608, 8388607, 32767, -32768, 8388607, 8388607, 8388607, 8388607),
              0, none);
      add_row(mk_ray(-8388608, -8388608, 16384, 16384, -8388608, -8388608, 0, 0), 0, none);
      add_row(mk_ray(0, 0, 1, 2, -100, 50, 200, 0), 0, none);
      add_row(mk_ray(0, 0, -1, -2, -100, -60, 200, 0), 0, none);
      add_row(mk_ray(-40000, -30000, 13107, 9830, 0, 0, 0, 40000), 0, none);
      add_row(mk_ray(50000, 50000, -16384, -16384, 0, 0, 8388607, 8388607), 0, none);
      add_row(mk_ray(-1, -1, 32767, 32767, -8388608, -8388608, 8388607, 8388607), 0, none);
      thr_set = '{15'd0, 15'd16384, 15'd32767, 15'd40, 15'd1};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (rays[i]) send_ray(rays[i].ray, rays[i].typed, rays[i].hit);
      for (int p = 0; p < 5; p++) begin
         write_thr(p == 3 ? 15'($urandom_range(200)) : thr_set[p]);
         phase_num = p;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_quiet = (p == 2 && i >= 100 && i < 300);
            send_ray(rand_ray(), 1'b0, none);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (hit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
